// File: rtl/pulse_tone_channel_core_macros.svh
// Assertion macros shared by the pulse tone channel RTL.
// No dependencies; included by the modules that carry checks.
`ifndef PULSE_TONE_CHANNEL_CORE_MACROS_SVH
`define PULSE_TONE_CHANNEL_CORE_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define PTC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pulse tone channel check failed");

// Next-cycle implication, held off while reset is asserted.
`define PTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pulse tone channel check failed");

`endif

// File: rtl/ptc_pkg.sv
// Types, codes and tables of the pulse tone channel.
// No dependencies; imported by every module of the block.
package ptc_pkg;

    typedef enum logic [2:0] {
        KIND_REG_WRITE   = 3'd0,
        KIND_ENABLE      = 3'd1,
        KIND_TIMER_TICK  = 3'd2,
        KIND_QUARTER     = 3'd3,
        KIND_HALF        = 3'd4
    } t_kind;

    localparam logic [1:0] REG_CONTROL   = 2'd0;
    localparam logic [1:0] REG_SWEEP     = 2'd1;
    localparam logic [1:0] REG_PERIOD_LO = 2'd2;
    localparam logic [1:0] REG_PERIOD_HI = 2'd3;

    localparam logic [10:0] PERIOD_MIN = 11'd8;
    localparam logic [3:0]  LEVEL_MAX  = 4'd15;

    // One request as it travels from the input register into the channel.
    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] reg_index;
        logic [7:0] reg_value;
        logic       enable_bit;
    } t_event;

    // Sweep target and its range flags.
    typedef struct packed {
        logic [10:0] target;
        logic        negative;
        logic        overflow;
    } t_sweep;

    // Duty patterns, bit n is sequencer step n.
    localparam logic [7:0] DUTY_TABLE [4] = '{8'h02, 8'h06, 8'h1E, 8'hF9};

    function automatic logic [7:0] length_lookup(input logic [4:0] code);
        logic [7:0] len;
        case (code)
            5'd0:  len = 8'd10;
            5'd1:  len = 8'd254;
            5'd2:  len = 8'd20;
            5'd3:  len = 8'd2;
            5'd4:  len = 8'd40;
            5'd5:  len = 8'd4;
            5'd6:  len = 8'd80;
            5'd7:  len = 8'd6;
            5'd8:  len = 8'd160;
            5'd9:  len = 8'd8;
            5'd10: len = 8'd60;
            5'd11: len = 8'd10;
            5'd12: len = 8'd14;
            5'd13: len = 8'd12;
            5'd14: len = 8'd26;
            5'd15: len = 8'd14;
            5'd16: len = 8'd12;
            5'd17: len = 8'd16;
            5'd18: len = 8'd24;
            5'd19: len = 8'd18;
            5'd20: len = 8'd48;
            5'd21: len = 8'd20;
            5'd22: len = 8'd96;
            5'd23: len = 8'd22;
            5'd24: len = 8'd192;
            5'd25: len = 8'd24;
            5'd26: len = 8'd72;
            5'd27: len = 8'd26;
            5'd28: len = 8'd16;
            5'd29: len = 8'd28;
            5'd30: len = 8'd32;
            5'd31: len = 8'd30;
            default: len = 8'd0;
        endcase
        return len;
    endfunction

endpackage

// File: rtl/ptc_sweep_unit.sv
// Sweep target calculation: period plus or minus the shifted period.
// Depends on ptc_pkg.
module ptc_sweep_unit
    import ptc_pkg::*;
(
    input  logic [10:0] i_period,
    input  logic [2:0]  i_amount,
    input  logic        i_down,
    input  logic        i_first_variant,
    output t_sweep      o_sweep
);

    logic [10:0] change;
    logic [11:0] sum;
    logic [12:0] diff;

    always_comb begin
        change = i_period >> i_amount;
        sum    = {1'b0, i_period} + {1'b0, change};
        // extra one off for the first-channel variant
        diff   = {2'b00, i_period} - {2'b00, change} - {12'd0, i_first_variant};
        if (i_down) begin
            o_sweep.target   = diff[10:0];
            o_sweep.negative = diff[12];
            o_sweep.overflow = 1'b0;
        end else begin
            o_sweep.target   = sum[10:0];
            o_sweep.negative = 1'b0;
            o_sweep.overflow = sum[11];
        end
    end

endmodule

// File: rtl/ptc_channel_state.sv
// Channel state registers and the per-request update with level output.
// Depends on ptc_pkg, ptc_sweep_unit and the assertion macro header.
`include "pulse_tone_channel_core_macros.svh"

module ptc_channel_state
    import ptc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_event     i_event,
    input  logic       i_first_variant,
    output logic [3:0] o_level,
    output logic       o_length_nonzero
);

    logic [1:0]  r_duty_mode,        n_duty_mode;
    logic        r_halt_loop,        n_halt_loop;
    logic        r_fixed_volume,     n_fixed_volume;
    logic [3:0]  r_volume_period,    n_volume_period;
    logic [3:0]  r_env_divider,      n_env_divider;
    logic [3:0]  r_env_level,        n_env_level;
    logic        r_env_restart,      n_env_restart;
    logic        r_sweep_on,         n_sweep_on;
    logic [2:0]  r_sweep_div_period, n_sweep_div_period;
    logic        r_sweep_down,       n_sweep_down;
    logic [2:0]  r_sweep_amount,     n_sweep_amount;
    logic        r_sweep_reload,     n_sweep_reload;
    logic [2:0]  r_sweep_divider,    n_sweep_divider;
    logic [10:0] r_tone_period,      n_tone_period;
    logic [10:0] r_tone_countdown,   n_tone_countdown;
    logic [2:0]  r_step_position,    n_step_position;
    logic [7:0]  r_length_count,     n_length_count;
    logic        r_channel_on,       n_channel_on;

    t_sweep w_sweep_now;
    t_sweep w_sweep_next;
    logic   w_muted;
    logic   w_duty_high;

    // target on the current period drives the half-frame update
    ptc_sweep_unit u_sweep_now (
        .i_period        (r_tone_period),
        .i_amount        (r_sweep_amount),
        .i_down          (r_sweep_down),
        .i_first_variant (i_first_variant),
        .o_sweep         (w_sweep_now)
    );

    // target on the updated period drives muting of the reported level
    ptc_sweep_unit u_sweep_next (
        .i_period        (n_tone_period),
        .i_amount        (n_sweep_amount),
        .i_down          (n_sweep_down),
        .i_first_variant (i_first_variant),
        .o_sweep         (w_sweep_next)
    );

    always_comb begin
        n_duty_mode        = r_duty_mode;
        n_halt_loop        = r_halt_loop;
        n_fixed_volume     = r_fixed_volume;
        n_volume_period    = r_volume_period;
        n_env_divider      = r_env_divider;
        n_env_level        = r_env_level;
        n_env_restart      = r_env_restart;
        n_sweep_on         = r_sweep_on;
        n_sweep_div_period = r_sweep_div_period;
        n_sweep_down       = r_sweep_down;
        n_sweep_amount     = r_sweep_amount;
        n_sweep_reload     = r_sweep_reload;
        n_sweep_divider    = r_sweep_divider;
        n_tone_period      = r_tone_period;
        n_tone_countdown   = r_tone_countdown;
        n_step_position    = r_step_position;
        n_length_count     = r_length_count;
        n_channel_on       = r_channel_on;

        if (i_step) begin
            case (i_event.kind)
                KIND_REG_WRITE: begin
                    case (i_event.reg_index)
                        REG_CONTROL: begin
                            n_duty_mode     = i_event.reg_value[7:6];
                            n_halt_loop     = i_event.reg_value[5];
                            n_fixed_volume  = i_event.reg_value[4];
                            n_volume_period = i_event.reg_value[3:0];
                        end
                        REG_SWEEP: begin
                            n_sweep_on         = i_event.reg_value[7];
                            n_sweep_div_period = i_event.reg_value[6:4];
                            n_sweep_down       = i_event.reg_value[3];
                            n_sweep_amount     = i_event.reg_value[2:0];
                            n_sweep_reload     = 1'b1;
                        end
                        REG_PERIOD_LO: begin
                            n_tone_period = {r_tone_period[10:8], i_event.reg_value};
                        end
                        default: begin
                            n_tone_period = {i_event.reg_value[2:0], r_tone_period[7:0]};
                            if (r_channel_on) begin
                                n_length_count = length_lookup(i_event.reg_value[7:3]);
                            end
                            n_env_restart   = 1'b1;
                            n_step_position = '0;
                        end
                    endcase
                end
                KIND_ENABLE: begin
                    n_channel_on = i_event.enable_bit;
                    if (!i_event.enable_bit) begin
                        n_length_count = '0;
                    end
                end
                KIND_TIMER_TICK: begin
                    if (r_tone_countdown == '0) begin
                        n_tone_countdown = r_tone_period;
                        n_step_position  = r_step_position + 3'd1;
                    end else begin
                        n_tone_countdown = r_tone_countdown - 11'd1;
                    end
                end
                KIND_QUARTER: begin
                    if (r_env_restart) begin
                        n_env_restart = 1'b0;
                        n_env_level   = LEVEL_MAX;
                        n_env_divider = r_volume_period;
                    end else if (r_env_divider == '0) begin
                        n_env_divider = r_volume_period;
                        if (r_env_level != '0) begin
                            n_env_level = r_env_level - 4'd1;
                        end else if (r_halt_loop) begin
                            n_env_level = LEVEL_MAX;
                        end
                    end else begin
                        n_env_divider = r_env_divider - 4'd1;
                    end
                end
                KIND_HALF: begin
                    if (!r_halt_loop && r_length_count != '0) begin
                        n_length_count = r_length_count - 8'd1;
                    end
                    // take the target only when it stays in range
                    if (r_sweep_divider == '0 && r_sweep_on && r_sweep_amount != '0
                        && r_tone_period >= PERIOD_MIN
                        && !w_sweep_now.negative && !w_sweep_now.overflow) begin
                        n_tone_period = w_sweep_now.target;
                    end
                    if (r_sweep_divider == '0 || r_sweep_reload) begin
                        n_sweep_divider = r_sweep_div_period;
                        n_sweep_reload  = 1'b0;
                    end else begin
                        n_sweep_divider = r_sweep_divider - 3'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // report the level of the state that this request leaves
    always_comb begin
        w_muted = (n_length_count == '0) || (n_tone_period < PERIOD_MIN)
                  || w_sweep_next.overflow;
        w_duty_high = DUTY_TABLE[n_duty_mode][n_step_position];
        if (!w_muted && w_duty_high) begin
            o_level = n_fixed_volume ? n_volume_period : n_env_level;
        end else begin
            o_level = '0;
        end
        o_length_nonzero = (n_length_count != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_mode        <= '0;
            r_halt_loop        <= 1'b0;
            r_fixed_volume     <= 1'b0;
            r_volume_period    <= '0;
            r_env_divider      <= '0;
            r_env_level        <= '0;
            r_env_restart      <= 1'b0;
            r_sweep_on         <= 1'b0;
            r_sweep_div_period <= '0;
            r_sweep_down       <= 1'b0;
            r_sweep_amount     <= '0;
            r_sweep_reload     <= 1'b0;
            r_sweep_divider    <= '0;
            r_tone_period      <= '0;
            r_tone_countdown   <= '0;
            r_step_position    <= '0;
            r_length_count     <= '0;
            r_channel_on       <= 1'b0;
        end else begin
            r_duty_mode        <= n_duty_mode;
            r_halt_loop        <= n_halt_loop;
            r_fixed_volume     <= n_fixed_volume;
            r_volume_period    <= n_volume_period;
            r_env_divider      <= n_env_divider;
            r_env_level        <= n_env_level;
            r_env_restart      <= n_env_restart;
            r_sweep_on         <= n_sweep_on;
            r_sweep_div_period <= n_sweep_div_period;
            r_sweep_down       <= n_sweep_down;
            r_sweep_amount     <= n_sweep_amount;
            r_sweep_reload     <= n_sweep_reload;
            r_sweep_divider    <= n_sweep_divider;
            r_tone_period      <= n_tone_period;
            r_tone_countdown   <= n_tone_countdown;
            r_step_position    <= n_step_position;
            r_length_count     <= n_length_count;
            r_channel_on       <= n_channel_on;
        end
    end

    `PTC_ASSERT_SAME(a_level_needs_length, i_clk, i_rst_n,
        (o_level != '0), o_length_nonzero)
    `PTC_ASSERT_SAME(a_short_period_mutes, i_clk, i_rst_n,
        (n_tone_period < PERIOD_MIN), (o_level == '0))
    `PTC_ASSERT_NEXT(a_disable_clears_length, i_clk, i_rst_n,
        (i_step && i_event.kind == KIND_ENABLE && !i_event.enable_bit),
        (r_length_count == '0 && !r_channel_on))

endmodule

// File: rtl/pulse_tone_channel_core.sv
// Top level of the pulse tone channel: request and result registers around
// the channel state. Depends on ptc_pkg, ptc_channel_state and the macro header.
//
// Usage:
//   Requests enter on i_in_valid / o_in_ready with i_kind, i_reg_index,
//   i_reg_value and i_enable_bit; kind selects a register write, an enable
//   write, a timer tick, a quarter-frame clock or a half-frame clock.
//   Every request yields exactly one result on o_out_valid / i_out_ready:
//   o_level (4-bit output volume) and o_length_nonzero.
//   An accepted request waits in the request register until the result
//   slot is free or being taken; then the channel state is updated and the
//   result is registered and shown on o_out_valid, to be taken while
//   i_out_ready is high. One request per cycle while the receiver does not
//   stall, set by the single channel state update between the two registers.
//   The user must write the first-channel sweep variant through i_cfg_wr_en /
//   i_cfg_wr_data only while no request is in flight; the block does not check.
//   Reset (i_rst_n low, synchronous) clears all channel state, the variant
//   bit and both valid flags.
//   When the receiver stalls, the result register holds, the request
//   register holds one more request, and o_in_ready drops once both are full.
`include "pulse_tone_channel_core_macros.svh"

module pulse_tone_channel_core
    import ptc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_kind,
    input  logic [1:0] i_reg_index,
    input  logic [7:0] i_reg_value,
    input  logic       i_enable_bit,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_level,
    output logic       o_length_nonzero
);

    logic       r_in_valid;
    t_event     r_event;
    logic       r_out_valid;
    logic [3:0] r_level;
    logic       r_length_nonzero;
    logic       r_first_variant;

    logic       w_advance;
    logic       w_step;
    logic [3:0] w_level;
    logic       w_length_nonzero;

    // advance the pipe whenever the result slot is free or being taken
    assign w_advance  = !r_out_valid || i_out_ready;
    assign w_step     = r_in_valid && w_advance;
    assign o_in_ready = !r_in_valid || w_advance;

    ptc_channel_state u_state (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (w_step),
        .i_event          (r_event),
        .i_first_variant  (r_first_variant),
        .o_level          (w_level),
        .o_length_nonzero (w_length_nonzero)
    );

    // variant bit: the user writes it only while idle; the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_variant <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_first_variant <= i_cfg_wr_data;
        end
    end

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_event.kind       <= i_kind;
            r_event.reg_index  <= i_reg_index;
            r_event.reg_value  <= i_reg_value;
            r_event.enable_bit <= i_enable_bit;
        end
    end

    // result register: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_level          <= w_level;
            r_length_nonzero <= w_length_nonzero;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_level          = r_level;
    assign o_length_nonzero = r_length_nonzero;

    `PTC_ASSERT_NEXT(a_stalled_request_kept, i_clk, i_rst_n,
        (r_in_valid && !w_advance), (r_in_valid && $stable(r_event)))
    `PTC_ASSERT_NEXT(a_step_gives_result, i_clk, i_rst_n,
        w_step, r_out_valid)

endmodule
